[rtl/tlbpt_pkg.sv]
package tlbpt_pkg;

  localparam int ADDR_W = 16;
  localparam int COUNT_W = 32;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int OFFSET_BITS_DEF = 8;
  localparam int PAGE_BITS_DEF = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

[rtl/tlb_page_translation_top.sv]
// demand-paged address translation behind a fifo tlb
// input channel: a logical address on logical_address is taken at a clock
// edge where start is high and busy is low; busy stays low, so one
// transaction can be issued in every cycle
// the upper bits give the page, the low OFFSET_BITS bits the offset
// result channel: done is high for one cycle with physical_address,
// tlb_hit, page_fault and the saturating totals hit_total / fault_total
// the address and s_valid are registered at the accepting edge, then done
// and the result are registered from s_valid
// throughput: one address per cycle; the page table is a memory read
// at the accepting edge, the tlb search, page table check and state update
// happen in the following cycle, so each transaction sees the one before it
// a miss pushes the mapping at the front of the tlb, the oldest drops out;
// a page with no frame takes the next free frame in order
// reset clears the tlb fill count, the page mapped bits, the frame
// allocator and both totals; transactions in flight are dropped
// the receiver cannot stall: each result is shown for exactly one cycle
module tlb_page_translation_top import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [ADDR_W-1:0]  logical_address,
  output logic               done,
  output logic [ADDR_W-1:0]  physical_address,
  output logic               tlb_hit,
  output logic               page_fault,
  output logic [COUNT_W-1:0] hit_total,
  output logic [COUNT_W-1:0] fault_total
);

  localparam int NUM_PAGES = 1 << PAGE_BITS;
  localparam int AEXT_W = ADDR_W + OFFSET_BITS + PAGE_BITS;
  localparam int PEXT_W = ADDR_W + PAGE_BITS + OFFSET_BITS;

  logic                   accept;
  logic [AEXT_W-1:0]      in_ext;
  logic [PAGE_BITS-1:0]   in_page;

  logic                   s_valid;
  logic [PAGE_BITS-1:0]   s_page;
  logic [OFFSET_BITS-1:0] s_offset;

  logic [PAGE_BITS-1:0]   page_frames [NUM_PAGES];
  logic [PAGE_BITS-1:0]   mem_rd;
  logic [NUM_PAGES-1:0]   page_valid;
  logic [PAGE_BITS:0]     next_free_frame;

  logic                   lk_hit;
  logic [PAGE_BITS-1:0]   lk_frame;
  logic                   mapped;
  logic                   fault_now;
  logic                   push;
  logic [PAGE_BITS-1:0]   alloc_frame;
  logic [PAGE_BITS-1:0]   frame;
  logic [PEXT_W-1:0]      phys_ext;

  assign busy = 1'b0;
  assign accept = start && !busy;

  assign in_ext = AEXT_W'(logical_address);
  assign in_page = in_ext[OFFSET_BITS +: PAGE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_page <= in_page;
      s_offset <= in_ext[OFFSET_BITS-1:0];
    end
  end

  // a page written by the transaction ahead is in the tlb by now, so the
  // stale read data in that case is never used
  always_ff @(posedge clk) begin
    if (fault_now) begin
      page_frames[s_page] <= alloc_frame;
    end
    if (accept) begin
      mem_rd <= page_frames[in_page];
    end
  end

  tlbpt_tlb #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_BITS(PAGE_BITS)
  ) u_tlb (
    .clk(clk),
    .rst(rst),
    .page(s_page),
    .push(push),
    .push_frame(frame),
    .hit(lk_hit),
    .frame(lk_frame)
  );

  assign mapped = page_valid[s_page];
  assign alloc_frame = next_free_frame[PAGE_BITS-1:0];
  assign fault_now = s_valid && !lk_hit && !mapped;
  assign push = s_valid && !lk_hit;

  always_comb begin
    if (lk_hit) begin
      frame = lk_frame;
    end else if (mapped) begin
      frame = mem_rd;
    end else begin
      frame = alloc_frame;
    end
  end

  assign phys_ext = PEXT_W'({frame, s_offset});

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= '0;
      next_free_frame <= '0;
      hit_total <= '0;
      fault_total <= '0;
      done <= 1'b0;
    end else begin
      done <= s_valid;
      if (s_valid && lk_hit) begin
        hit_total <= sat_inc(hit_total);
      end
      if (fault_now) begin
        page_valid[s_page] <= 1'b1;
        fault_total <= sat_inc(fault_total);
        if (next_free_frame != (PAGE_BITS+1)'(NUM_PAGES)) begin
          next_free_frame <= next_free_frame + (PAGE_BITS+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      physical_address <= phys_ext[ADDR_W-1:0];
      tlb_hit <= lk_hit;
      page_fault <= fault_now;
    end
  end

endmodule

[rtl/tlbpt_tlb.sv]
module tlbpt_tlb import tlbpt_pkg::*; #(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 push,
  input  logic [PAGE_BITS-1:0] push_frame,
  output logic                 hit,
  output logic [PAGE_BITS-1:0] frame
);

  localparam int FILL_W = $clog2(TLB_ENTRIES + 1);

  logic [PAGE_BITS-1:0] tags   [TLB_ENTRIES];
  logic [PAGE_BITS-1:0] frames [TLB_ENTRIES];
  logic [FILL_W-1:0]    fill;
  logic [TLB_ENTRIES-1:0] entry_valid;

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      entry_valid[i] = FILL_W'(i) < fill;
    end
  end

  // newest matching entry wins: index 0 is the newest
  always_comb begin
    hit = 1'b0;
    frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && tags[i] == page) begin
        hit = 1'b1;
        frame = frames[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tags[0] <= page;
      frames[0] <= push_frame;
      for (int i = 1; i < TLB_ENTRIES; i++) begin
        tags[i] <= tags[i-1];
        frames[i] <= frames[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push && fill != FILL_W'(TLB_ENTRIES)) begin
      fill <= fill + FILL_W'(1);
    end
  end

endmodule

[rtl/tlbpt_checker.sv]
module tlbpt_checker import tlbpt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [ADDR_W-1:0]  logical_address,
  input logic               done,
  input logic               tlb_hit,
  input logic               page_fault,
  input logic [COUNT_W-1:0] fault_total
);

  // a hit never faults
  assert property (@(posedge clk) disable iff (rst)
    done |-> !(tlb_hit && page_fault))
    else $error("hit and fault flagged together");

  // every accepted transaction yields a result, registered through s_valid and then done
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result missing after accepted transaction");

  // no result without an earlier accepted transaction
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without transaction");

  // back to back faults count up by one until saturation
  assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && page_fault && $past(fault_total) != COUNT_MAX)
      |-> fault_total == $past(fault_total) + COUNT_W'(1))
    else $error("fault total did not advance");

  // the same address in transactions accepted back to back hits the second time
  assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && $past(rst) == 1'b0 &&
     $past(logical_address, 2) == $past(logical_address, 3) &&
     $past(start && !busy, 3))
      |-> tlb_hit)
    else $error("repeated address missed the tlb");

endmodule

bind tlb_page_translation_top tlbpt_checker u_tlbpt_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .logical_address(logical_address),
  .done(done),
  .tlb_hit(tlb_hit),
  .page_fault(page_fault),
  .fault_total(fault_total)
);

[verif/tlb_page_translation_top_tb.sv]
module tlb_page_translation_top_tb;
  import tlbpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PAGES = 1 << PAGE_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOT_POOL = 20;
  localparam int DIR_ROWS = 23;

  typedef struct packed {
    logic [ADDR_W-1:0]  phys;
    logic               hit;
    logic               fault;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
  } xlat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              typed;
    xlat_t             want;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [ADDR_W-1:0]  logical_address = '0;
  logic               busy;
  logic               done;
  logic [ADDR_W-1:0]  physical_address;
  logic               tlb_hit;
  logic               page_fault;
  logic [COUNT_W-1:0] hit_total;
  logic [COUNT_W-1:0] fault_total;

  // shadow copy of the translation state
  logic [PAGE_BITS_DEF-1:0] tlb_tag [TLB_ENTRIES_DEF];
  logic [PAGE_BITS_DEF-1:0] tlb_frm [TLB_ENTRIES_DEF];
  int                       tlb_used = 0;
  logic                     pt_valid [NUM_PAGES];
  logic [PAGE_BITS_DEF-1:0] pt_frame [NUM_PAGES];
  logic [PAGE_BITS_DEF:0]   next_frame = '0;
  logic [COUNT_W-1:0]       hit_cnt = '0;
  logic [COUNT_W-1:0]       fault_cnt = '0;

  xlat_t pending_xlat [$];
  int    fail_count = 0;
  int    cycle_count = 0;

  // directed rows: typed expectations right after reset, the rest predicted
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1, 32'd0, 32'd1}},
    '{16'h00FF, 1'b1, '{16'h00FF, 1'b1, 1'b0, 32'd1, 32'd1}},
    '{16'hFFFF, 1'b1, '{16'h01FF, 1'b0, 1'b1, 32'd1, 32'd2}},
    '{16'hFF00, 1'b1, '{16'h0100, 1'b1, 1'b0, 32'd2, 32'd2}},
    '{16'h0180, 1'b0, '0},
    '{16'h0201, 1'b0, '0},
    '{16'h0302, 1'b0, '0},
    '{16'h0455, 1'b0, '0},
    '{16'h05AA, 1'b0, '0},
    '{16'h06FE, 1'b0, '0},
    '{16'h0700, 1'b0, '0},
    '{16'h0811, 1'b0, '0},
    '{16'h0922, 1'b0, '0},
    '{16'h0A33, 1'b0, '0},
    '{16'h0B44, 1'b0, '0},
    '{16'h0C66, 1'b0, '0},
    '{16'h0D77, 1'b0, '0},
    '{16'h0E88, 1'b0, '0},
    '{16'h0F99, 1'b0, '0},
    '{16'h10AA, 1'b0, '0},
    // pages 0 and 255 have been evicted: tlb miss, page table hit
    '{16'h0042, 1'b0, '0},
    '{16'hFF7E, 1'b0, '0},
    '{16'h10BB, 1'b0, '0}
  };

  tlb_page_translation_top dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .logical_address  (logical_address),
    .done             (done),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hit_total        (hit_total),
    .fault_total      (fault_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int p = 0; p < NUM_PAGES; p++) begin
      pt_valid[p] = 1'b0;
      pt_frame[p] = '0;
    end
    for (int e = 0; e < TLB_ENTRIES_DEF; e++) begin
      tlb_tag[e] = '0;
      tlb_frm[e] = '0;
    end
  end

  function automatic xlat_t translate_addr(input logic [ADDR_W-1:0] va);
    logic [PAGE_BITS_DEF-1:0]   page;
    logic [OFFSET_BITS_DEF-1:0] ofs;
    logic [PAGE_BITS_DEF-1:0]   frame;
    logic                       hit;
    logic                       flt;
    xlat_t                      r;
    page = PAGE_BITS_DEF'(va >> OFFSET_BITS_DEF);
    ofs = va[OFFSET_BITS_DEF-1:0];
    frame = '0;
    hit = 1'b0;
    flt = 1'b0;
    // newest matching entry wins
    for (int i = 0; i < tlb_used; i++) begin
      if (!hit && tlb_tag[i] == page) begin
        frame = tlb_frm[i];
        hit = 1'b1;
      end
    end
    if (hit) begin
      hit_cnt = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + COUNT_W'(1);
    end else begin
      if (!pt_valid[page]) begin
        pt_frame[page] = next_frame[PAGE_BITS_DEF-1:0];
        pt_valid[page] = 1'b1;
        if (next_frame < (PAGE_BITS_DEF+1)'(NUM_PAGES))
          next_frame = next_frame + (PAGE_BITS_DEF+1)'(1);
        fault_cnt = (fault_cnt == COUNT_MAX) ? fault_cnt : fault_cnt + COUNT_W'(1);
        flt = 1'b1;
      end
      frame = pt_frame[page];
      if (tlb_used < TLB_ENTRIES_DEF) tlb_used++;
      for (int i = tlb_used - 1; i > 0; i--) begin
        tlb_tag[i] = tlb_tag[i-1];
        tlb_frm[i] = tlb_frm[i-1];
      end
      tlb_tag[0] = page;
      tlb_frm[0] = frame;
    end
    r.phys = ADDR_W'({frame, ofs});
    r.hit = hit;
    r.fault = flt;
    r.hits = hit_cnt;
    r.faults = fault_cnt;
    return r;
  endfunction

  // drive one address, wait for the accepting edge, then, when gap is above zero, drop start and idle for the gap
  task automatic issue(input logic [ADDR_W-1:0] va, input int gap,
                       input logic typed, input xlat_t want);
    xlat_t pred;
    start <= 1'b1;
    logical_address <= va;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = translate_addr(va);
    pending_xlat.push_back(typed ? want : pred);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 99) < 30) ? $urandom_range(1, 13) : 0;
  endfunction

  function automatic logic [ADDR_W-1:0] mixed_addr(ref logic [PAGE_BITS_DEF-1:0] pool []);
    int slot;
    if ($urandom_range(0, 99) < 30) return ADDR_W'($urandom);
    slot = $urandom_range(0, HOT_POOL - 1);
    if ($urandom_range(0, 99) < 5) pool[slot] = PAGE_BITS_DEF'($urandom);
    return ADDR_W'({pool[slot], OFFSET_BITS_DEF'($urandom)});
  endfunction

  initial begin
    logic [PAGE_BITS_DEF-1:0] pool [];
    int                       order [NUM_PAGES];
    int                       j;
    int                       tmp;

    pool = new[HOT_POOL];
    for (int k = 0; k < HOT_POOL; k++) pool[k] = PAGE_BITS_DEF'($urandom);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      issue(dir_rows[r].addr, pick_gap(), dir_rows[r].typed, dir_rows[r].want);

    // working set with tlb reuse and eviction
    for (int n = 0; n < 400; n++) issue(mixed_addr(pool), pick_gap(), 1'b0, '0);

    // touch every page in shuffled order until the frame allocator runs out
    for (int p = 0; p < NUM_PAGES; p++) order[p] = p;
    for (int p = NUM_PAGES - 1; p > 0; p--) begin
      j = $urandom_range(0, p);
      tmp = order[p];
      order[p] = order[j];
      order[j] = tmp;
    end
    for (int p = 0; p < NUM_PAGES; p++)
      issue(ADDR_W'({PAGE_BITS_DEF'(order[p]), OFFSET_BITS_DEF'($urandom)}),
            pick_gap(), 1'b0, '0);

    // drain the pipe before going on
    start <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);

    for (int n = 0; n < 200; n++) issue(mixed_addr(pool), pick_gap(), 1'b0, '0);

    // back to back, no idling
    for (int n = 0; n < 150; n++) issue(mixed_addr(pool), 0, 1'b0, '0);

    start <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending_xlat.size() == 0) begin
      $display("[tlb_page_translation_top] OK");
    end else begin
      $display("[tlb_page_translation_top] ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    xlat_t got;
    xlat_t want;
    if (!rst && done) begin
      got = '{physical_address, tlb_hit, page_fault, hit_total, fault_total};
      if (pending_xlat.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result: phys=%h hit=%b fault=%b hits=%0d faults=%0d",
                   got.phys, got.hit, got.fault, got.hits, got.faults);
        fail_count++;
      end else begin
        want = pending_xlat.pop_front();
        if (got !== want) begin
          if (fail_count < 10) begin
            $display("mismatch: exp phys=%h hit=%b fault=%b hits=%0d faults=%0d",
                     want.phys, want.hit, want.fault, want.hits, want.faults);
            $display("          got phys=%h hit=%b fault=%b hits=%0d faults=%0d",
                     got.phys, got.hit, got.fault, got.hits, got.faults);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[tlb_page_translation_top] ERROR");
      $finish;
    end
  end

endmodule

[files.f]
rtl/tlbpt_pkg.sv
rtl/tlbpt_tlb.sv
rtl/tlb_page_translation_top.sv
rtl/tlbpt_checker.sv
verif/tlb_page_translation_top_tb.sv
